[rtl/core/mppt_pkg.sv]
package mppt_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned DELTA_W   = 9;
  localparam int unsigned BUTTONS_W = 3;
  localparam int unsigned SUM_W     = 12;  // cursor plus displacement, signed
  localparam int unsigned OUT_W     = 48;  // 41 field bits padded to whole bytes

  // Header bit positions
  localparam int unsigned SIGN_X_POS = 4;
  localparam int unsigned SIGN_Y_POS = 5;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MAX_X = 1'b0,
    REG_MAX_Y = 1'b1
  } reg_index_t;

  // Clamp limits after reset
  localparam logic [POS_W-1:0] MAX_X_RESET = 10'd368;
  localparam logic [POS_W-1:0] MAX_Y_RESET = 10'd256;

  // Place of the next byte within a packet
  typedef enum logic [1:0] {
    IDX_HEADER = 2'd0,
    IDX_X      = 2'd1,
    IDX_Y      = 2'd2,
    IDX_SPARE  = 2'd3
  } byte_index_t;

  // One finished packet
  typedef struct packed {
    logic signed [DELTA_W-1:0]   delta_y;
    logic signed [DELTA_W-1:0]   delta_x;
    logic        [POS_W-1:0]     pos_y;
    logic        [POS_W-1:0]     pos_x;
    logic        [BUTTONS_W-1:0] buttons;
  } result_t;

  // Add a displacement to a position and clamp the sum to 0..limit
  function automatic logic [POS_W-1:0] move_clamped(
    input logic        [POS_W-1:0]   pos,
    input logic signed [DELTA_W-1:0] delta,
    input logic        [POS_W-1:0]   limit
  );
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        res;
    sum = $signed({2'b00, pos}) + SUM_W'(delta);
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (sum > $signed({2'b00, limit})) begin
      res = limit;
    end else begin
      res = sum[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/mouse_packet_position_tracker_core.sv]
// Channel   Dir  Width  Contents
// s_axis    in   8      data_byte: one raw mouse byte
// m_axis    out  48     buttons, pos_x, pos_y, delta_x, delta_y (one word per packet)
// cfg       in   10     max_x (index 0), max_y (index 1), write only
//
// A byte is taken into an input register, then decoded combinationally: header and
// X bytes are stored, the Y byte updates both cursors and loads the result register.
// One byte per cycle is sustained unless a held result stalls a Y byte in the input register.
// Reset (synchronous) clears the byte count and cursors and restores the limits.
// A held result stalls only a Y byte behind it; header and X bytes keep flowing.
module mouse_packet_position_tracker_core (
  input  logic                          clk,
  input  logic                          rst,
  // data_byte [7:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mppt_pkg::BYTE_W-1:0]   s_axis_tdata,
  // buttons [2:0], pos_x [12:3], pos_y [22:13], delta_x [31:23], delta_y [40:32], zero above
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mppt_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [mppt_pkg::POS_W-1:0]    cfg_data
);

  logic                           in_valid;
  logic [mppt_pkg::BYTE_W-1:0]    in_byte;
  mppt_pkg::byte_index_t          byte_index;
  mppt_pkg::byte_index_t          byte_index_next;
  logic [mppt_pkg::BYTE_W-1:0]    header_byte;
  logic [mppt_pkg::BYTE_W-1:0]    x_byte;
  logic [mppt_pkg::POS_W-1:0]     cursor_x;
  logic [mppt_pkg::POS_W-1:0]     cursor_y;
  logic [mppt_pkg::POS_W-1:0]     max_x;
  logic [mppt_pkg::POS_W-1:0]     max_y;
  logic                           out_valid;
  mppt_pkg::result_t              result;
  mppt_pkg::result_t              result_next;
  logic                           completes;
  logic                           advance;

  // A byte completes a packet unless it is a header or X byte
  assign completes = (byte_index != mppt_pkg::IDX_HEADER) &&
                     (byte_index != mppt_pkg::IDX_X);
  assign advance   = in_valid && (!completes || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Decode the packet and move the cursors
  always_comb begin
    result_next.buttons = header_byte[mppt_pkg::BUTTONS_W-1:0];
    result_next.delta_x = $signed({header_byte[mppt_pkg::SIGN_X_POS], x_byte});
    result_next.delta_y = $signed({header_byte[mppt_pkg::SIGN_Y_POS], in_byte});
    result_next.pos_x   = mppt_pkg::move_clamped(cursor_x, result_next.delta_x, max_x);
    result_next.pos_y   = mppt_pkg::move_clamped(cursor_y, result_next.delta_y, max_y);
    case (byte_index)
      mppt_pkg::IDX_HEADER: byte_index_next = mppt_pkg::IDX_X;
      mppt_pkg::IDX_X:      byte_index_next = mppt_pkg::IDX_Y;
      default:              byte_index_next = mppt_pkg::IDX_HEADER;
    endcase
  end

  // Hold the incoming word until the decode stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // Write the clamp limits
  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= mppt_pkg::MAX_X_RESET;
      max_y <= mppt_pkg::MAX_Y_RESET;
    end else if (cfg_wr_en) begin
      case (mppt_pkg::reg_index_t'(cfg_index))
        mppt_pkg::REG_MAX_X: max_x <= cfg_data;
        mppt_pkg::REG_MAX_Y: max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the packet state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= mppt_pkg::IDX_HEADER;
      header_byte <= '0;
      x_byte      <= '0;
      cursor_x    <= '0;
      cursor_y    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (advance && completes) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        byte_index <= byte_index_next;
        case (byte_index)
          mppt_pkg::IDX_HEADER: header_byte <= in_byte;
          mppt_pkg::IDX_X:      x_byte      <= in_byte;
          default: begin
            cursor_x  <= result_next.pos_x;
            cursor_y  <= result_next.pos_y;
          end
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance && completes) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = mppt_pkg::OUT_W'(result);

endmodule

[bench/mouse_packet_position_tracker_core_tb.sv]
`timescale 1ns / 1ps

module mouse_packet_position_tracker_core_tb;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned SHOWN_LIMIT    = 10;
  localparam int unsigned IDLE_PERCENT   = 33;
  localparam int unsigned HOLD_AFTER     = 120;   // packets seen before the long hold-off
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_BYTES    = 140;
  localparam int unsigned STEADY_PHASE   = 6;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned PACKET_BYTES   = 3;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [mppt_pkg::BYTE_W-1:0]     s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [mppt_pkg::OUT_W-1:0]      m_axis_tdata;
  logic                            cfg_wr_en     = 1'b0;
  mppt_pkg::reg_index_t            cfg_index     = mppt_pkg::REG_MAX_X;
  logic [mppt_pkg::POS_W-1:0]      cfg_data      = '0;

  logic [mppt_pkg::BYTE_W-1:0]     pending_bytes[$];
  mppt_pkg::result_t               expected_packets[$];
  bit                              steady_flow   = 1'b0;
  int unsigned                     mismatches    = 0;
  int unsigned                     packets_seen  = 0;
  int unsigned                     hold_count    = 0;
  int unsigned                     cycle_count   = 0;

  // Tracker state mirrored from the block
  mppt_pkg::byte_index_t           next_slot     = mppt_pkg::IDX_HEADER;
  logic [mppt_pkg::BYTE_W-1:0]     held_header   = '0;
  logic [mppt_pkg::BYTE_W-1:0]     held_x        = '0;
  logic [mppt_pkg::POS_W-1:0]      track_x       = '0;
  logic [mppt_pkg::POS_W-1:0]      track_y       = '0;
  logic [mppt_pkg::POS_W-1:0]      limit_x       = mppt_pkg::MAX_X_RESET;
  logic [mppt_pkg::POS_W-1:0]      limit_y       = mppt_pkg::MAX_Y_RESET;

  mouse_packet_position_tracker_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Move a cursor by a displacement, held within 0..lim
  function automatic logic [mppt_pkg::POS_W-1:0] step_cursor(
    logic [mppt_pkg::POS_W-1:0] cur, int delta, logic [mppt_pkg::POS_W-1:0] lim);
    int target;
    target = int'(cur) + delta;
    if (target < 0) begin
      target = 0;
    end else if (target > int'(lim)) begin
      target = int'(lim);
    end
    return target[mppt_pkg::POS_W-1:0];
  endfunction

  // Magnitude byte plus header sign bit gives a value in -256..255
  function automatic int signed_offset(logic [mppt_pkg::BYTE_W-1:0] mag, logic neg);
    return neg ? int'(mag) - 256 : int'(mag);
  endfunction

  // Advance the packet tracker by one byte; a Y byte yields one packet
  function automatic void track_mouse_byte(logic [mppt_pkg::BYTE_W-1:0] b);
    mppt_pkg::result_t pkt;
    int      dx;
    int      dy;
    case (next_slot)
      mppt_pkg::IDX_HEADER: begin
        held_header = b;
        next_slot   = mppt_pkg::IDX_X;
      end
      mppt_pkg::IDX_X: begin
        held_x    = b;
        next_slot = mppt_pkg::IDX_Y;
      end
      default: begin
        dx          = signed_offset(held_x, held_header[mppt_pkg::SIGN_X_POS]);
        dy          = signed_offset(b, held_header[mppt_pkg::SIGN_Y_POS]);
        track_x     = step_cursor(track_x, dx, limit_x);
        track_y     = step_cursor(track_y, dy, limit_y);
        pkt.buttons = held_header[mppt_pkg::BUTTONS_W-1:0];
        pkt.pos_x   = track_x;
        pkt.pos_y   = track_y;
        pkt.delta_x = dx[mppt_pkg::DELTA_W-1:0];
        pkt.delta_y = dy[mppt_pkg::DELTA_W-1:0];
        expected_packets.push_back(pkt);
        next_slot   = mppt_pkg::IDX_HEADER;
      end
    endcase
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    mismatches++;
    if (mismatches <= SHOWN_LIMIT) begin
      $display("packet %0d %s: expected %0d, got %0d", packets_seen, field, want, got);
    end
  endfunction

  // Compare one output word with the oldest expected packet
  function automatic void check_packet(logic [mppt_pkg::OUT_W-1:0] word);
    mppt_pkg::result_t got;
    mppt_pkg::result_t want;
    got = mppt_pkg::result_t'(word[$bits(mppt_pkg::result_t)-1:0]);
    if (expected_packets.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_LIMIT) begin
        $display("packet %0d arrived with none expected: %h", packets_seen, word);
      end
    end else begin
      want = expected_packets.pop_front();
      if (got.buttons != want.buttons) note_mismatch("buttons", want.buttons, got.buttons);
      if (got.pos_x != want.pos_x) note_mismatch("pos_x", want.pos_x, got.pos_x);
      if (got.pos_y != want.pos_y) note_mismatch("pos_y", want.pos_y, got.pos_y);
      if (got.delta_x != want.delta_x) begin
        note_mismatch("delta_x", $signed(want.delta_x), $signed(got.delta_x));
      end
      if (got.delta_y != want.delta_y) begin
        note_mismatch("delta_y", $signed(want.delta_y), $signed(got.delta_y));
      end
    end
    packets_seen++;
  endfunction

  // Offer pending bytes, predicting each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_mouse_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          s_axis_tdata  <= pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Take output words; hold off once for a long stretch to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_packet(m_axis_tdata);
      if (packets_seen >= HOLD_AFTER && hold_count < HOLD_CYCLES) begin
        hold_count++;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic set_limit(mppt_pkg::reg_index_t idx, logic [mppt_pkg::POS_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == mppt_pkg::REG_MAX_X) begin
      limit_x = value;
    end else begin
      limit_y = value;
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every byte is taken and every packet has come, then let the pipe empty
  task automatic settle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_packets.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [mppt_pkg::POS_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return mppt_pkg::POS_W'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    logic [mppt_pkg::BYTE_W-1:0] opening[$];
    logic [mppt_pkg::BYTE_W-1:0] packet_bytes[PACKET_BYTES];
    int                slot;
    int                dx;
    int                dy;

    // Reset limits: saturate high, swing to full negative, ignored header bits,
    // small signed steps and a clamp at zero
    opening = '{8'h00, 8'hFF, 8'hFF,  8'h07, 8'hFF, 8'hFF,
                8'h37, 8'h00, 8'h00,  8'hC8, 8'h7F, 8'h80,
                8'h10, 8'hFF, 8'h01,  8'h25, 8'h00, 8'hFF,
                8'h12, 8'h01, 8'h00};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (opening[i]) pending_bytes.push_back(opening[i]);
    settle();

    // Widest limits, then collapse both to zero to pull the cursor back
    set_limit(mppt_pkg::REG_MAX_X, '1);
    set_limit(mppt_pkg::REG_MAX_Y, '1);
    @(negedge clk);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'hFF);
    settle();
    set_limit(mppt_pkg::REG_MAX_X, '0);
    set_limit(mppt_pkg::REG_MAX_Y, '0);
    @(negedge clk);
    repeat (PACKET_BYTES) pending_bytes.push_back(8'h00);
    settle();

    // Random packets; framing carries across phases, so limits change mid-packet too
    slot = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_limit(mppt_pkg::REG_MAX_X, pick_limit());
      set_limit(mppt_pkg::REG_MAX_Y, pick_limit());
      @(negedge clk);
      steady_flow = (phase == STEADY_PHASE);
      repeat (PHASE_BYTES) begin
        if (slot == 0) begin
          if ($urandom_range(0, 9) < 7) begin
            dx = int'($urandom_range(0, 40)) - 20;
            dy = int'($urandom_range(0, 40)) - 20;
          end else begin
            dx = int'($urandom_range(0, 511)) - 256;
            dy = int'($urandom_range(0, 511)) - 256;
          end
          packet_bytes[0]                      = mppt_pkg::BYTE_W'($urandom_range(0, 255));
          packet_bytes[0][mppt_pkg::SIGN_X_POS] = (dx < 0);
          packet_bytes[0][mppt_pkg::SIGN_Y_POS] = (dy < 0);
          packet_bytes[1]                      = dx[mppt_pkg::BYTE_W-1:0];
          packet_bytes[2]                      = dy[mppt_pkg::BYTE_W-1:0];
        end
        pending_bytes.push_back(packet_bytes[slot]);
        slot = (slot + 1) % PACKET_BYTES;
      end
      settle();
    end

    steady_flow = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_packets.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/mppt_pkg.sv
rtl/core/mouse_packet_position_tracker_core.sv
bench/mouse_packet_position_tracker_core_tb.sv
